[sv/mtcr_pkg.sv]
// mtcr_pkg: types, constants and the cell render function for the
// text cell renderer; no dependencies
package mtcr_pkg;

  localparam int unsigned LenW  = 10;
  localparam int unsigned RowW  = 36;
  localparam int unsigned Cols  = 8;
  localparam int unsigned NibW  = 4;

  localparam logic [LenW-1:0] RunLimit    = 10'd882;
  localparam logic [LenW-1:0] PixelBuffer = 10'd720;
  localparam logic [LenW-1:0] CellWidth   = 10'd9;

  localparam logic [3:0] IntenNormal  = 4'h9;
  localparam logic [3:0] IntenBright  = 4'hd;
  localparam logic [4:0] UnderlineRow = 5'd13;
  localparam logic [2:0] UnderlineAttr = 3'd1;
  localparam logic [2:0] LineDrawTop  = 3'b110;

  localparam logic [7:0] AttrHidden0  = 8'h00;
  localparam logic [7:0] AttrHidden1  = 8'h08;
  localparam logic [7:0] AttrHidden2  = 8'h80;
  localparam logic [7:0] AttrHidden3  = 8'h88;
  localparam logic [7:0] AttrInverse0 = 8'h70;
  localparam logic [7:0] AttrInverse1 = 8'h78;
  localparam logic [7:0] AttrInverse2 = 8'hf0;
  localparam logic [7:0] AttrInverse3 = 8'hf8;

  typedef enum logic [1:0] {
    KIND_SYNC   = 2'd0,
    KIND_BORDER = 2'd1,
    KIND_PIXELS = 2'd2
  } kind_e;

  typedef struct packed {
    logic            pixels_valid;
    logic [RowW-1:0] pixel_row;
    logic            flush_valid;
    logic [1:0]      flush_kind;
    logic [LenW-1:0] flush_length;
    logic            flush_after_pixels;
  } result_t;

  function automatic logic [RowW-1:0] render_cell(
    input logic [4:0] row,
    input logic [7:0] glyph,
    input logic [7:0] attr,
    input logic [7:0] font
  );
    logic [3:0]      inten;
    logic [3:0]      ninth;
    logic [7:0]      bits;
    logic [RowW-1:0] acc;
    inten = attr[3] ? IntenBright : IntenNormal;
    ninth = '0;
    bits  = font;
    acc   = '0;
    case (attr) inside
      AttrHidden0, AttrHidden1, AttrHidden2, AttrHidden3: begin
        bits = '0;
      end
      AttrInverse0, AttrInverse1, AttrInverse2, AttrInverse3: begin
        bits  = ~font;
        ninth = inten;
      end
      default: begin
      end
    endcase
    if (attr[2:0] == UnderlineAttr && row == UnderlineRow) begin
      acc = {9{inten}};
    end else begin
      for (int i = 0; i < Cols; i++) begin
        acc[RowW-1-NibW*i -: NibW] = bits[Cols-1-i] ? inten : 4'h0;
      end
      if (glyph[7:5] == LineDrawTop) begin
        acc[NibW-1:0] = bits[0] ? inten : 4'h0;
      end else begin
        acc[NibW-1:0] = ninth;
      end
    end
    return acc;
  endfunction

endpackage

[sv/mda_text_cell_renderer.sv]
// mda_text_cell_renderer: top level, classes and renders one character cell
// per transaction and tracks run lengths; depends on mtcr_pkg
//
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_ready_o | sync flags, row, glyph, attr, font
// out     | output    | out_valid_o/out_ready_i | pixels and flush report
//
// render and run bookkeeping sit between the run state and the result
// register, one new transaction can enter every cycle while in_ready_o is high.
// a two-entry output (result register plus skid register) keeps input ready
// while one result waits; in_ready_o drops only when both are full.
// reset clears the run state to sync with zero length and empties the output.
module mda_text_cell_renderer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      hsync_i,
  input  logic                      vsync_i,
  input  logic                      display_enable_i,
  input  logic [4:0]                row_address_i,
  input  logic [7:0]                glyph_i,
  input  logic [7:0]                attribute_byte_i,
  input  logic [7:0]                font_bits_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      pixels_valid_o,
  output logic [mtcr_pkg::RowW-1:0] pixel_row_o,
  output logic                      flush_valid_o,
  output logic [1:0]                flush_kind_o,
  output logic [mtcr_pkg::LenW-1:0] flush_length_o,
  output logic                      flush_after_pixels_o
);
  import mtcr_pkg::*;

  kind_e           class_q, class_d, next_kind, cls;
  logic [LenW-1:0] len_q, len_d, len0, len1;
  logic            brk, fl_change, buf_full;
  result_t         res, out_q, skid_q;
  logic            out_valid_q, skid_valid_q;
  logic            in_fire, out_free;

  assign in_ready_o = ~skid_valid_q;
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  always_comb begin
    if (hsync_i | vsync_i) begin
      next_kind = KIND_SYNC;
    end else if (display_enable_i) begin
      next_kind = KIND_PIXELS;
    end else begin
      next_kind = KIND_BORDER;
    end
    brk       = (next_kind != class_q) || (len_q > RunLimit);
    fl_change = brk && (len_q != '0);
    cls       = brk ? next_kind : class_q;
    len0      = brk ? '0 : len_q;
    len1      = len0 + CellWidth;
    buf_full  = (cls == KIND_PIXELS) && !fl_change && (len1 >= PixelBuffer);
    class_d   = cls;
    len_d     = buf_full ? '0 : len1;

    res.pixels_valid = (cls == KIND_PIXELS);
    res.pixel_row    = (cls == KIND_PIXELS) ?
        render_cell(row_address_i, glyph_i, attribute_byte_i, font_bits_i) : '0;
    res.flush_valid  = fl_change | buf_full;
    res.flush_after_pixels = buf_full;
    if (fl_change) begin
      res.flush_kind   = class_q;
      res.flush_length = len_q;
    end else if (buf_full) begin
      res.flush_kind   = KIND_PIXELS;
      res.flush_length = len1;
    end else begin
      res.flush_kind   = KIND_SYNC;
      res.flush_length = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_q      <= KIND_SYNC;
      len_q        <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        class_q <= class_d;
        len_q   <= len_d;
      end
      if (out_free) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= res;
      end
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign pixels_valid_o       = out_q.pixels_valid;
  assign pixel_row_o          = out_q.pixel_row;
  assign flush_valid_o        = out_q.flush_valid;
  assign flush_kind_o         = out_q.flush_kind;
  assign flush_length_o       = out_q.flush_length;
  assign flush_after_pixels_o = out_q.flush_after_pixels;

endmodule

[sv/mtcr_checker.sv]
// mtcr_checker: port-level checks on the text cell renderer results,
// bound to mda_text_cell_renderer; depends on mtcr_pkg
module mtcr_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      pixels_valid_o,
  input logic [mtcr_pkg::RowW-1:0] pixel_row_o,
  input logic                      flush_valid_o,
  input logic [1:0]                flush_kind_o,
  input logic [mtcr_pkg::LenW-1:0] flush_length_o,
  input logic                      flush_after_pixels_o
);
  import mtcr_pkg::*;

  // no pixels means a blank row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pixels_valid_o |-> pixel_row_o == '0)
    else $error("pixel row set without pixels");

  // buffer-full flush only comes with this transaction's pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flush_after_pixels_o |->
      flush_valid_o && pixels_valid_o && flush_kind_o == KIND_PIXELS)
    else $error("bad buffer-full flush");

  // an idle flush report is all zero, a real one is never empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (flush_valid_o ? (flush_length_o != '0)
                     : (flush_kind_o == KIND_SYNC && flush_length_o == '0)))
    else $error("flush report inconsistent");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(pixel_row_o) && $stable(flush_length_o))
    else $error("stalled result changed");

  // input held off only while a result is waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind mda_text_cell_renderer mtcr_checker u_mtcr_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_ready_o           (in_ready_o),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .pixels_valid_o       (pixels_valid_o),
  .pixel_row_o          (pixel_row_o),
  .flush_valid_o        (flush_valid_o),
  .flush_kind_o         (flush_kind_o),
  .flush_length_o       (flush_length_o),
  .flush_after_pixels_o (flush_after_pixels_o)
);

[verif/mda_text_cell_renderer_tb.sv]
// mda_text_cell_renderer_tb: self-checking testbench for the text cell renderer,
// predicts pixels and run flush reports per transaction and compares each result
// depends on mtcr_pkg and mda_text_cell_renderer
module mda_text_cell_renderer_tb;
  import mtcr_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int PrintCap   = 40;

  localparam logic [7:0] HiddenAttrs [4] = '{AttrHidden0, AttrHidden1, AttrHidden2,
                                              AttrHidden3};
  localparam logic [7:0] InverseAttrs [4] = '{AttrInverse0, AttrInverse1, AttrInverse2,
                                               AttrInverse3};

  typedef struct packed {
    logic       hsync;
    logic       vsync;
    logic       de;
    logic [4:0] row;
    logic [7:0] glyph;
    logic [7:0] attr;
    logic [7:0] font;
  } cell_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic hsync_i;
  logic vsync_i;
  logic display_enable_i;
  logic [4:0] row_address_i;
  logic [7:0] glyph_i;
  logic [7:0] attribute_byte_i;
  logic [7:0] font_bits_i;
  logic out_valid_o;
  logic out_ready_i;
  logic pixels_valid_o;
  logic [RowW-1:0] pixel_row_o;
  logic flush_valid_o;
  logic [1:0] flush_kind_o;
  logic [LenW-1:0] flush_length_o;
  logic flush_after_pixels_o;

  kind_e           run_kind;
  logic [LenW-1:0] run_len;
  result_t         cell_outcomes[$];
  int              error_count;
  int              cells_offered;
  int              cycle_count;
  int              sink_hold_len;
  bit              src_idle_en;
  bit              sink_idle_en;

  mda_text_cell_renderer dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [RowW-1:0] cell_intensities(input cell_t c);
    logic [3:0]      lvl;
    logic [8:0]      lit;
    logic [RowW-1:0] px;
    lvl = c.attr[3] ? IntenBright : IntenNormal;
    lit = {c.font, 1'b0};
    if (c.attr == AttrHidden0 || c.attr == AttrHidden1 || c.attr == AttrHidden2 ||
        c.attr == AttrHidden3) begin
      lit = '0;
    end else if (c.attr == AttrInverse0 || c.attr == AttrInverse1 ||
                 c.attr == AttrInverse2 || c.attr == AttrInverse3) begin
      lit = {~c.font, 1'b1};
    end
    if (c.glyph[7:5] == LineDrawTop) begin
      lit[0] = lit[1];
    end
    if (c.attr[2:0] == UnderlineAttr && c.row == UnderlineRow) begin
      lit = '1;
    end
    for (int i = 0; i < 9; i++) begin
      px[RowW-1-4*i -: 4] = lit[8-i] ? lvl : 4'h0;
    end
    return px;
  endfunction

  function automatic result_t cell_outcome(input cell_t c);
    result_t r;
    kind_e   nk;
    r = '0;
    if (c.hsync || c.vsync) begin
      nk = KIND_SYNC;
    end else if (c.de) begin
      nk = KIND_PIXELS;
    end else begin
      nk = KIND_BORDER;
    end
    if (nk != run_kind || run_len > RunLimit) begin
      if (run_len != '0) begin
        r.flush_valid  = 1'b1;
        r.flush_kind   = run_kind;
        r.flush_length = run_len;
      end
      run_kind = nk;
      run_len  = '0;
    end
    if (run_kind == KIND_PIXELS) begin
      r.pixels_valid = 1'b1;
      r.pixel_row    = cell_intensities(c);
    end
    run_len = run_len + CellWidth;
    if (run_kind == KIND_PIXELS && !r.flush_valid && run_len >= PixelBuffer) begin
      r.flush_valid        = 1'b1;
      r.flush_kind         = KIND_PIXELS;
      r.flush_length       = run_len;
      r.flush_after_pixels = 1'b1;
      run_len              = '0;
    end
    return r;
  endfunction

  function automatic int idle_length();
    if ($urandom_range(0, 19) == 0) begin
      return $urandom_range(20, 60);
    end
    return $urandom_range(1, 4);
  endfunction

  function automatic cell_t mk_cell(input logic hs, input logic vs, input logic de,
                                    input logic [4:0] row, input logic [7:0] glyph,
                                    input logic [7:0] attr, input logic [7:0] font);
    cell_t c;
    c = '{hsync: hs, vsync: vs, de: de, row: row, glyph: glyph, attr: attr, font: font};
    return c;
  endfunction

  function automatic cell_t random_cell(input kind_e k);
    cell_t      c;
    logic [1:0] sy;
    c.row   = ($urandom_range(0, 3) == 0) ? UnderlineRow : 5'($urandom);
    c.glyph = ($urandom_range(0, 3) == 0) ? {LineDrawTop, 5'($urandom)} : 8'($urandom);
    c.font  = 8'($urandom);
    case ($urandom_range(0, 5))
      0: c.attr = HiddenAttrs[$urandom_range(0, 3)];
      1: c.attr = InverseAttrs[$urandom_range(0, 3)];
      2: c.attr = {5'($urandom), UnderlineAttr};
      default: c.attr = 8'($urandom);
    endcase
    case (k)
      KIND_SYNC: begin
        sy      = 2'($urandom_range(1, 3));
        c.hsync = sy[0];
        c.vsync = sy[1];
        c.de    = 1'($urandom);
      end
      KIND_BORDER: begin
        c.hsync = 1'b0;
        c.vsync = 1'b0;
        c.de    = 1'b0;
      end
      default: begin
        c.hsync = 1'b0;
        c.vsync = 1'b0;
        c.de    = 1'b1;
      end
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < PrintCap) begin
      $display("mismatch: %s", msg);
    end
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // one transaction on the input channel, then an optional random gap
  task automatic offer_cell(input cell_t c);
    int gap;
    hsync_i          <= c.hsync;
    vsync_i          <= c.vsync;
    display_enable_i <= c.de;
    row_address_i    <= c.row;
    glyph_i          <= c.glyph;
    attribute_byte_i <= c.attr;
    font_bits_i      <= c.font;
    in_valid_i       <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    cell_outcomes.push_back(cell_outcome(c));
    cells_offered++;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = idle_length();
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_run(input kind_e k, input int n);
    for (int i = 0; i < n; i++) begin
      offer_cell(random_cell(k));
    end
  endtask

  task automatic send_noise(input int n);
    cell_t c;
    for (int i = 0; i < n; i++) begin
      c = cell_t'($urandom);
      offer_cell(c);
    end
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (cell_outcomes.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_cells();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    // empty sync run after reset is not reported
    offer_cell(mk_cell(1'b0, 1'b0, 1'b0, 5'd0, 8'h00, 8'h00, 8'h00));
    offer_cell(mk_cell(1'b0, 1'b0, 1'b1, 5'd0, 8'h00, AttrHidden0, 8'hff));
    offer_cell(mk_cell(1'b0, 1'b0, 1'b1, 5'd31, 8'hff, AttrHidden1, 8'hff));
    offer_cell(mk_cell(1'b0, 1'b0, 1'b1, 5'd7, 8'h41, AttrHidden2, 8'hff));
    offer_cell(mk_cell(1'b0, 1'b0, 1'b1, 5'd3, 8'hc4, AttrHidden3, 8'h5a));
    offer_cell(mk_cell(1'b0, 1'b0, 1'b1, 5'd1, 8'h41, AttrInverse0, 8'ha5));
    offer_cell(mk_cell(1'b0, 1'b0, 1'b1, 5'd2, 8'hc3, AttrInverse1, 8'h00));
    offer_cell(mk_cell(1'b0, 1'b0, 1'b1, 5'd4, 8'hdf, AttrInverse2, 8'hff));
    offer_cell(mk_cell(1'b0, 1'b0, 1'b1, 5'd5, 8'he0, AttrInverse3, 8'h81));
    offer_cell(mk_cell(1'b0, 1'b0, 1'b1, UnderlineRow, 8'h20, {5'd0, UnderlineAttr}, 8'h00));
    offer_cell(mk_cell(1'b0, 1'b0, 1'b1, UnderlineRow, 8'hc8, {5'd1, UnderlineAttr}, 8'h18));
    offer_cell(mk_cell(1'b0, 1'b0, 1'b1, 5'd12, 8'h20, {5'd0, UnderlineAttr}, 8'h3c));
    offer_cell(mk_cell(1'b0, 1'b0, 1'b1, UnderlineRow, 8'hff, 8'hff, 8'hff));
    offer_cell(mk_cell(1'b0, 1'b0, 1'b1, 5'd6, 8'hc0, 8'h07, 8'h01));
    offer_cell(mk_cell(1'b0, 1'b0, 1'b1, 5'd8, 8'hdf, 8'h0f, 8'hfe));
    offer_cell(mk_cell(1'b0, 1'b0, 1'b1, 5'd9, 8'hbf, 8'h07, 8'h01));
    offer_cell(mk_cell(1'b1, 1'b0, 1'b0, 5'd0, 8'h00, 8'h00, 8'h00));
    offer_cell(mk_cell(1'b0, 1'b1, 1'b1, 5'd10, 8'h55, 8'h07, 8'haa));
    offer_cell(mk_cell(1'b1, 1'b1, 1'b1, 5'd31, 8'hff, 8'hff, 8'hff));
    offer_cell(mk_cell(1'b0, 1'b0, 1'b0, 5'd31, 8'hff, 8'hff, 8'hff));
    offer_cell(mk_cell(1'b0, 1'b0, 1'b0, 5'd0, 8'h00, 8'h00, 8'h00));
    offer_cell(mk_cell(1'b0, 1'b0, 1'b1, 5'd0, 8'h00, 8'h07, 8'h00));
    offer_cell(mk_cell(1'b1, 1'b0, 1'b1, 5'd0, 8'h00, 8'h07, 8'h00));
    wait_results_done();
  endtask

  // runs right at and past the run limit and the pixel buffer size
  task automatic test_long_runs();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_run(KIND_BORDER, 98);
    send_run(KIND_SYNC, 99);
    send_run(KIND_BORDER, $urandom_range(100, 120));
    send_run(KIND_PIXELS, 80);
    send_run(KIND_SYNC, $urandom_range(100, 120));
    send_run(KIND_PIXELS, $urandom_range(160, 200));
    send_run(KIND_BORDER, 1);
    send_run(KIND_PIXELS, 79);
    send_run(KIND_SYNC, 2);
    wait_results_done();
  endtask

  task automatic test_backpressure();
    src_idle_en   = 1'b0;
    sink_idle_en  = 1'b0;
    sink_hold_len = 300;
    send_run(KIND_PIXELS, 20);
    send_noise(20);
    wait_results_done();
  endtask

  task automatic test_random_runs();
    int    target;
    int    n;
    kind_e k;
    target = cells_offered + 200;
    while (cells_offered < target) begin
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 120) : $urandom_range(1, 20);
      if ($urandom_range(0, 9) == 0) begin
        send_noise(n);
      end else begin
        k = kind_e'($urandom_range(0, 2));
        send_run(k, n);
      end
      if ($urandom_range(0, 11) == 0) begin
        wait_results_done();
      end
    end
    wait_results_done();
  endtask

  initial begin : result_sink
    int n;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (sink_hold_len != 0) begin
        out_ready_i <= 1'b0;
        for (n = 0; n < sink_hold_len; n++) @(posedge clk_i);
        sink_hold_len = 0;
        out_ready_i <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        n = idle_length();
        repeat (n) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : outcome_compare
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cell_outcomes.size() == 0) begin
        report_mismatch("result transaction with no expectation pending");
      end else begin
        want = cell_outcomes.pop_front();
        check_field("pixels_valid", 64'(pixels_valid_o), 64'(want.pixels_valid));
        check_field("pixel_row", 64'(pixel_row_o), 64'(want.pixel_row));
        check_field("flush_valid", 64'(flush_valid_o), 64'(want.flush_valid));
        check_field("flush_kind", 64'(flush_kind_o), 64'(want.flush_kind));
        check_field("flush_length", 64'(flush_length_o), 64'(want.flush_length));
        check_field("flush_after_pixels", 64'(flush_after_pixels_o),
                    64'(want.flush_after_pixels));
      end
    end
  end

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  initial begin
    error_count   = 0;
    cells_offered = 0;
    sink_hold_len = 0;
    src_idle_en   = 1'b0;
    sink_idle_en  = 1'b0;
    run_kind      = KIND_SYNC;
    run_len       = '0;
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    hsync_i          <= 1'b0;
    vsync_i          <= 1'b0;
    display_enable_i <= 1'b0;
    row_address_i    <= '0;
    glyph_i          <= '0;
    attribute_byte_i <= '0;
    font_bits_i      <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cells();
    test_long_runs();
    test_backpressure();
    test_random_runs();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
